// File: design/device_table_lru_tracker_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the device table tracker.
// ----------------------------------------------------------------------------
`ifndef DEVICE_TABLE_LRU_TRACKER_CORE_ASSERT_SVH
`define DEVICE_TABLE_LRU_TRACKER_CORE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define DTLT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DTLT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/dtlt_pkg.sv
// ----------------------------------------------------------------------------
// dtlt_pkg
// Sizes, codes and shared types of the device table tracker.
// ----------------------------------------------------------------------------
package dtlt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam int PROTO_W = 8;
   localparam int DEV_W   = 32;
   localparam int CHAN_W  = 8;
   localparam int KEY_W   = PROTO_W + DEV_W + CHAN_W;
   localparam int TIME_W  = 48;
   localparam int MSG_W   = 32;
   localparam int SLOT_W  = 6;
   localparam int ACT_W   = 7;
   localparam int TMO_W   = 16;

   localparam int MS_PER_SECOND = 1000;
   localparam int MS_W          = 10;
   localparam int WIN_W         = TMO_W + MS_W;

   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd60;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_COUNT  = 1'b1
   } op_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] latest;
      logic [TIME_W-1:0] origin;
      logic [MSG_W-1:0]  tally;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // latch the accepted word, clear scan state
      logic rd_en;    // read table at the scan address, advance it
      logic commit;   // write back the entry on update, load the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;  // scan address is at the last entry
      logic rsp_free;   // output register can take a word this cycle
   } status_type;

endpackage

// File: design/dtlt_req_if.sv
// ----------------------------------------------------------------------------
// dtlt_req_if
// Request channel: one update or count query word per handshake.
// ----------------------------------------------------------------------------
interface dtlt_req_if;
   import dtlt_pkg::*;

   logic                valid;
   logic                ready;
   op_type              op;
   logic [PROTO_W-1:0]  protocol;
   logic [DEV_W-1:0]    unit_id;
   logic [CHAN_W-1:0]   channel;
   logic [TIME_W-1:0]   time_ms;

   modport source (output valid, op, protocol, unit_id, channel, time_ms, input ready);
   modport sink   (input valid, op, protocol, unit_id, channel, time_ms, output ready);
endinterface

// File: design/dtlt_rsp_if.sv
// ----------------------------------------------------------------------------
// dtlt_rsp_if
// Response channel: one result word per request.
// ----------------------------------------------------------------------------
interface dtlt_rsp_if;
   import dtlt_pkg::*;

   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  slot;
   logic               hit;
   logic               evicted;
   logic [MSG_W-1:0]   message_count;
   logic [TIME_W-1:0]  origin_ms;
   logic [ACT_W-1:0]   active_count;

   modport source (output valid, slot, hit, evicted, message_count, origin_ms,
                   active_count, input ready);
   modport sink   (input valid, slot, hit, evicted, message_count, origin_ms,
                   active_count, output ready);
endinterface

// File: design/dtlt_ctrl.sv
// ----------------------------------------------------------------------------
// dtlt_ctrl
// Sequencer: accept, scan the table, drain the read pipe, commit.
// ----------------------------------------------------------------------------
module dtlt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dtlt_pkg::status_type status,
   output dtlt_pkg::cmd_type    cmd
);
   import dtlt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/dtlt_dp.sv
// ----------------------------------------------------------------------------
// dtlt_dp
// Table memory, valid bits, scan pipe, write-back and output register.
// ----------------------------------------------------------------------------
module dtlt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [dtlt_pkg::TMO_W-1:0]    csr_wdata,
   input  dtlt_pkg::cmd_type             cmd,
   output dtlt_pkg::status_type          status,
   input  dtlt_pkg::op_type              req_op,
   input  logic [dtlt_pkg::PROTO_W-1:0]  req_protocol,
   input  logic [dtlt_pkg::DEV_W-1:0]    req_unit_id,
   input  logic [dtlt_pkg::CHAN_W-1:0]   req_channel,
   input  logic [dtlt_pkg::TIME_W-1:0]   req_time_ms,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [dtlt_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_hit,
   output logic                          rsp_evicted,
   output logic [dtlt_pkg::MSG_W-1:0]    rsp_message_count,
   output logic [dtlt_pkg::TIME_W-1:0]   rsp_origin_ms,
   output logic [dtlt_pkg::ACT_W-1:0]    rsp_active_count
);
   import dtlt_pkg::*;

   `include "device_table_lru_tracker_core_assert.svh"

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   entry_type mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   logic [TMO_W-1:0]  timeout_ff;
   op_type            op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [TIME_W-1:0] now_ff;
   logic [WIN_W-1:0]  window_ff;
   logic [TIME_W-1:0] cutoff_ff;

   logic [IDX_W-1:0]  addr_ff;
   logic              pipe_vld_ff;
   logic [IDX_W-1:0]  pipe_idx_ff;
   entry_type         rd_data_ff;

   logic              found_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [MSG_W-1:0]  hit_cnt_ff;
   logic [TIME_W-1:0] hit_first_ff;
   logic              have_free_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic              have_old_ff;
   logic [IDX_W-1:0]  old_idx_ff;
   logic [TIME_W-1:0] old_time_ff;
   logic [CNT_W-1:0]  active_cnt_ff;

   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_hit_ff;
   logic              rsp_evicted_ff;
   logic [MSG_W-1:0]  rsp_count_ff;
   logic [TIME_W-1:0] rsp_first_ff;
   logic [ACT_W-1:0]  rsp_active_ff;

   logic              cur_valid;
   logic              evict_sel;
   logic [IDX_W-1:0]  slot_sel;
   logic [MSG_W-1:0]  count_sel;
   logic [TIME_W-1:0] first_sel;
   logic              do_update;

   assign status.scan_last = (addr_ff == LAST_IDX);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign cur_valid = valid_ff[pipe_idx_ff];
   assign do_update = cmd.commit && (op_ff == OP_UPDATE);

   // Slot choice: match, else lowest free, else oldest valid.
   always_comb begin
      evict_sel = !found_ff && !have_free_ff;
      if (found_ff) begin
         slot_sel  = hit_idx_ff;
         count_sel = (hit_cnt_ff == '1) ? hit_cnt_ff : hit_cnt_ff + MSG_W'(1);
         first_sel = hit_first_ff;
      end else begin
         slot_sel  = have_free_ff ? free_idx_ff : old_idx_ff;
         count_sel = MSG_W'(1);
         first_sel = now_ff;
      end
   end

   // config register and time window
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         key_ff    <= {req_protocol, req_unit_id, req_channel};
         now_ff    <= req_time_ms;
         window_ff <= WIN_W'(timeout_ff) * WIN_W'(MS_PER_SECOND);
      end
      // settles during the first scan cycle, before entry 0 is examined
      cutoff_ff <= (now_ff > TIME_W'(window_ff)) ? now_ff - TIME_W'(window_ff) : '0;
   end

   // table memory: one read port for the scan, one write port for commit
   always_ff @(posedge clock) begin
      if (cmd.rd_en) rd_data_ff <= mem[addr_ff];
      if (do_update) mem[slot_sel] <= '{key: key_ff, latest: now_ff,
                                         origin: first_sel, tally: count_sel};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (do_update) begin
         valid_ff[slot_sel] <= 1'b1;
      end
   end

   // scan address and read pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         if (cmd.load) addr_ff <= '0;
         else if (cmd.rd_en) addr_ff <= addr_ff + IDX_W'(1);
         pipe_vld_ff <= cmd.rd_en;
      end
      pipe_idx_ff <= addr_ff;
   end

   // per-entry scan results
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         found_ff      <= 1'b0;
         have_free_ff  <= 1'b0;
         have_old_ff   <= 1'b0;
         active_cnt_ff <= '0;
      end else if (pipe_vld_ff) begin
         if (op_ff == OP_COUNT) begin
            if (cur_valid && rd_data_ff.latest >= cutoff_ff)
               active_cnt_ff <= active_cnt_ff + CNT_W'(1);
         end else if (!found_ff) begin
            if (cur_valid) begin
               if (rd_data_ff.key == key_ff) begin
                  found_ff     <= 1'b1;
                  hit_idx_ff   <= pipe_idx_ff;
                  hit_cnt_ff   <= rd_data_ff.tally;
                  hit_first_ff <= rd_data_ff.origin;
               end else if (!have_old_ff || rd_data_ff.latest < old_time_ff) begin
                  // strict compare keeps the lowest index on ties
                  have_old_ff <= 1'b1;
                  old_idx_ff  <= pipe_idx_ff;
                  old_time_ff <= rd_data_ff.latest;
               end
            end else if (!have_free_ff) begin
               have_free_ff <= 1'b1;
               free_idx_ff  <= pipe_idx_ff;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         if (op_ff == OP_COUNT) begin
            rsp_slot_ff    <= '0;
            rsp_hit_ff     <= 1'b0;
            rsp_evicted_ff <= 1'b0;
            rsp_count_ff   <= '0;
            rsp_first_ff   <= '0;
            rsp_active_ff  <= ACT_W'(active_cnt_ff);
         end else begin
            rsp_slot_ff    <= SLOT_W'(slot_sel);
            rsp_hit_ff     <= found_ff;
            rsp_evicted_ff <= evict_sel;
            rsp_count_ff   <= count_sel;
            rsp_first_ff   <= first_sel;
            rsp_active_ff  <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted       = rsp_evicted_ff;
   assign rsp_message_count = rsp_count_ff;
   assign rsp_origin_ms     = rsp_first_ff;
   assign rsp_active_count  = rsp_active_ff;

   `DTLT_ASSERT(a_evict_only_when_full, (do_update && evict_sel) |-> (&valid_ff), "eviction with a free slot")
   `DTLT_ASSERT(a_commit_sets_valid, do_update |=> valid_ff[$past(slot_sel)], "committed slot not valid")
   `DTLT_ASSERT(a_commit_output_free, cmd.commit |-> (!rsp_valid_ff || rsp_ready), "output word overwritten")
   `DTLT_ASSERT_ALWAYS(a_count_bounded, reset || (active_cnt_ff <= CNT_W'(TABLE_ENTRIES)), "active count overflow")

endmodule

// File: design/device_table_lru_tracker_core.sv
// ----------------------------------------------------------------------------
// device_table_lru_tracker_core
// Associative device table with least-recently-seen replacement.
// ----------------------------------------------------------------------------
// Usage:
//  req_if carries one word per request: op 0 updates the entry keyed by
//  {protocol, unit_id, channel} at time_ms, op 1 counts entries whose
//  last-seen time is within csr timeout_seconds of time_ms.
//  rsp_if returns exactly one word per request, in request order.
//  csr_we/csr_wdata write timeout_seconds (reset 60); write only when idle.
// Timing:
//  Each request walks all TABLE_ENTRIES entries through the table memory's
//  single read port, one entry per cycle. The response word is registered,
//  and a new request is accepted only once the previous one has committed.
// Reset:
//  Synchronous, active high. All valid bits clear at once, so the table is
//  empty immediately; no clearing pass is needed.
// Stall:
//  The response sits in an output register. The next request is accepted
//  and scanned while it waits; its commit holds until the register drains.
// ----------------------------------------------------------------------------
module device_table_lru_tracker_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [dtlt_pkg::TMO_W-1:0] csr_wdata,
   dtlt_req_if.sink                   req_if,
   dtlt_rsp_if.source                 rsp_if
);
   import dtlt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   dtlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table, scan pipe and output register
   dtlt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_if.op),
      .req_protocol      (req_if.protocol),
      .req_unit_id       (req_if.unit_id),
      .req_channel       (req_if.channel),
      .req_time_ms       (req_if.time_ms),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_slot          (rsp_if.slot),
      .rsp_hit           (rsp_if.hit),
      .rsp_evicted       (rsp_if.evicted),
      .rsp_message_count (rsp_if.message_count),
      .rsp_origin_ms     (rsp_if.origin_ms),
      .rsp_active_count  (rsp_if.active_count)
   );

endmodule
